[rtl/core/rts_pkg.sv]
package rts_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);

  localparam logic [2:0] MODE_APPEND  = 3'd0;
  localparam logic [2:0] MODE_DELETE  = 3'd1;
  localparam logic [2:0] MODE_REPLACE = 3'd2;
  localparam logic [2:0] MODE_FIND    = 3'd3;
  localparam logic [2:0] MODE_SORT_UP = 3'd4;
  localparam logic [2:0] MODE_SORT_DN = 3'd5;
  localparam logic [2:0] MODE_CLEAR   = 3'd6;
  localparam logic [2:0] MODE_READ    = 3'd7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_CLASS = 3'd4;

  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_SHIFT = 2'd2;
  localparam logic [1:0] OP_SORT  = 2'd3;

  typedef struct packed {
    logic [1:0]                 op;
    logic                       odd;
    logic                       desc;
    logic [CNT_W-1:0]           cnt;
    logic [IDX_W-1:0]           sel;
    logic signed [KEY_BITS-1:0] wr_key;
    logic [1:0]                 wr_cls;
  } cell_ctl_t;

endpackage

[rtl/core/record_table_with_sort.sv]
// Record table with sort.
// Input channel (in_valid/in_ready) takes one command item: append, delete,
// replace, find, sort up, sort down, clear or read. Every command returns
// exactly one result item on the output channel (out_valid/out_ready) with a
// status, the entry position and record, and the entry total afterwards.
// The records live in a row of DEPTH cells; each cell holds one key and class
// and trades with its neighbors for delete (shift down) and sort (odd-even
// transposition, DEPTH phases, stable like a bubble sort).
// Append, clear, read and any command on an empty table answer at once from
// the idle state, with the result registered at acceptance. Find, delete and
// replace scan one entry a cycle from position 0 up to a match or the entry
// total; sort answers after its DEPTH phases.
// One command is in flight at a time; in_ready drops while a command works or
// a result waits, so the next item is taken only after the result leaves
// and a stalled receiver holds the block.
// Reset empties the table and drops any pending result; entry contents are
// not cleared, as they are unreachable until written.
module record_table_with_sort (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic signed [31:0] in_key_id,
  input  logic signed [31:0] in_new_id,
  input  logic [1:0]  in_new_class,
  input  logic [5:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_found_index,
  output logic signed [31:0] out_id,
  output logic [1:0]  out_class,
  output logic [6:0]  out_entry_total
);

  localparam int unsigned IW = rts_pkg::IDX_W;
  localparam int unsigned CW = rts_pkg::CNT_W;
  localparam int unsigned KW = rts_pkg::KEY_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_SORT = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic signed [KW-1:0] key_r, key_nxt;
  logic signed [KW-1:0] nkey_r, nkey_nxt;
  logic [1:0]  ncls_r, ncls_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [5:0]  oidx_r, oidx_nxt;
  logic signed [31:0] oid_r, oid_nxt;
  logic [1:0]  ocls_r, ocls_nxt;
  logic [6:0]  otot_r, otot_nxt;

  rts_pkg::cell_ctl_t ctl;

  logic signed [KW-1:0] cell_key [rts_pkg::DEPTH];
  logic [1:0]           cell_cls [rts_pkg::DEPTH];

  logic in_acc;
  logic signed [KW-1:0] in_key_w, in_nkey_w;
  logic [IW-1:0] ptr_idx;

  assign in_key_w  = KW'(in_key_id);
  assign in_nkey_w = KW'(in_new_id);
  assign ptr_idx   = ptr_r[IW-1:0];
  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign in_acc    = in_valid && in_ready;

  // row of cells; ends see no neighbor
  genvar g;
  generate
    for (g = 0; g < rts_pkg::DEPTH; g++) begin : g_cell
      logic signed [KW-1:0] up_k, dn_k;
      logic [1:0]           up_c, dn_c;
      if (g == rts_pkg::DEPTH - 1) begin : g_top
        assign up_k = '0;
        assign up_c = '0;
      end else begin : g_mid
        assign up_k = cell_key[g+1];
        assign up_c = cell_cls[g+1];
      end
      if (g == 0) begin : g_bot
        assign dn_k = '0;
        assign dn_c = '0;
      end else begin : g_rest
        assign dn_k = cell_key[g-1];
        assign dn_c = cell_cls[g-1];
      end
      rts_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .idx    (IW'(g)),
        .up_key (up_k),
        .up_cls (up_c),
        .dn_key (dn_k),
        .dn_cls (dn_c),
        .key    (cell_key[g]),
        .cls    (cell_cls[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    mode_nxt  = mode_r;
    key_nxt   = key_r;
    nkey_nxt  = nkey_r;
    ncls_nxt  = ncls_r;
    ov_nxt    = ov_r && !out_ready;
    ost_nxt   = ost_r;
    oidx_nxt  = oidx_r;
    oid_nxt   = oid_r;
    ocls_nxt  = ocls_r;
    otot_nxt  = otot_r;

    ctl        = '0;
    ctl.op     = rts_pkg::OP_HOLD;
    ctl.cnt    = cnt_r;
    ctl.odd    = ptr_r[0];
    ctl.desc   = (mode_r == rts_pkg::MODE_SORT_DN);
    ctl.sel    = ptr_idx;
    ctl.wr_key = nkey_r;
    ctl.wr_cls = ncls_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_mode;
          key_nxt  = in_key_w;
          nkey_nxt = in_nkey_w;
          ncls_nxt = in_new_class;
          ptr_nxt  = '0;
          ov_nxt   = 1'b1;
          ost_nxt  = rts_pkg::ST_OK;
          oidx_nxt = '0;
          oid_nxt  = '0;
          ocls_nxt = '0;
          otot_nxt = 7'(cnt_r);
          priority if (in_mode == rts_pkg::MODE_APPEND) begin
            if (in_new_class == 2'd0) begin
              ost_nxt = rts_pkg::ST_BAD_CLASS;
            end else if (cnt_r >= CW'(rts_pkg::DEPTH)) begin
              ost_nxt = rts_pkg::ST_FULL;
            end else begin
              ctl.op     = rts_pkg::OP_WRITE;
              ctl.sel    = cnt_r[IW-1:0];
              ctl.wr_key = in_nkey_w;
              ctl.wr_cls = in_new_class;
              cnt_nxt    = cnt_r + 1'b1;
              oidx_nxt   = 6'(cnt_r);
              oid_nxt    = 32'(in_nkey_w);
              ocls_nxt   = in_new_class;
              otot_nxt   = 7'(cnt_r + 1'b1);
            end
          end else if (cnt_r == '0) begin
            ost_nxt = rts_pkg::ST_EMPTY;
          end else if (in_mode == rts_pkg::MODE_DELETE ||
                       in_mode == rts_pkg::MODE_REPLACE ||
                       in_mode == rts_pkg::MODE_FIND) begin
            ov_nxt    = 1'b0;
            state_nxt = S_SCAN;
          end else if (in_mode == rts_pkg::MODE_SORT_UP ||
                       in_mode == rts_pkg::MODE_SORT_DN) begin
            ov_nxt    = 1'b0;
            state_nxt = S_SORT;
          end else if (in_mode == rts_pkg::MODE_CLEAR) begin
            cnt_nxt  = '0;
            otot_nxt = '0;
          end else begin
            if ({1'b0, in_read_index} >= 7'(cnt_r)) begin
              ost_nxt = rts_pkg::ST_NOT_FOUND;
            end else begin
              oidx_nxt = in_read_index;
              oid_nxt  = 32'(cell_key[IW'(in_read_index)]);
              ocls_nxt = cell_cls[IW'(in_read_index)];
            end
          end
        end
      end
      S_SCAN: begin
        if (ptr_r >= cnt_r) begin
          // walked off the end: no match
          state_nxt = S_IDLE;
          ov_nxt    = 1'b1;
          ost_nxt   = rts_pkg::ST_NOT_FOUND;
          oidx_nxt  = '0;
          oid_nxt   = '0;
          ocls_nxt  = '0;
          otot_nxt  = 7'(cnt_r);
        end else if (cell_key[ptr_idx] == key_r) begin
          state_nxt = S_IDLE;
          ov_nxt    = 1'b1;
          ost_nxt   = rts_pkg::ST_OK;
          oidx_nxt  = 6'(ptr_r);
          oid_nxt   = 32'(cell_key[ptr_idx]);
          ocls_nxt  = cell_cls[ptr_idx];
          otot_nxt  = 7'(cnt_r);
          if (mode_r == rts_pkg::MODE_DELETE) begin
            ctl.op   = rts_pkg::OP_SHIFT;
            cnt_nxt  = cnt_r - 1'b1;
            otot_nxt = 7'(cnt_r - 1'b1);
          end else if (mode_r == rts_pkg::MODE_REPLACE) begin
            if (ncls_r == 2'd0) begin
              ost_nxt  = rts_pkg::ST_BAD_CLASS;
              oidx_nxt = '0;
              oid_nxt  = '0;
              ocls_nxt = '0;
            end else begin
              ctl.op   = rts_pkg::OP_WRITE;
              oid_nxt  = 32'(nkey_r);
              ocls_nxt = ncls_r;
            end
          end
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_SORT: begin
        ctl.op  = rts_pkg::OP_SORT;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == CW'(rts_pkg::DEPTH - 1)) begin
          state_nxt = S_IDLE;
          ov_nxt    = 1'b1;
          ost_nxt   = rts_pkg::ST_OK;
          oidx_nxt  = '0;
          oid_nxt   = '0;
          ocls_nxt  = '0;
          otot_nxt  = 7'(cnt_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    key_r  <= key_nxt;
    nkey_r <= nkey_nxt;
    ncls_r <= ncls_nxt;
    ost_r  <= ost_nxt;
    oidx_r <= oidx_nxt;
    oid_r  <= oid_nxt;
    ocls_r <= ocls_nxt;
    otot_r <= otot_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_found_index = oidx_r;
  assign out_id          = oid_r;
  assign out_class       = ocls_r;
  assign out_entry_total = otot_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(rts_pkg::DEPTH))
    else $error("entry count above depth");

  a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> ptr_r <= cnt_r)
    else $error("scan pointer past entry count");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !ov_r)
    else $error("result pending while command works");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_mode == rts_pkg::MODE_CLEAR |=> cnt_r == '0)
    else $error("clear left entries");

endmodule

[rtl/core/rts_cell.sv]
module rts_cell (
  input  logic                               clk,
  input  rts_pkg::cell_ctl_t                 ctl,
  input  logic [rts_pkg::IDX_W-1:0]          idx,
  input  logic signed [rts_pkg::KEY_BITS-1:0] up_key,
  input  logic [1:0]                         up_cls,
  input  logic signed [rts_pkg::KEY_BITS-1:0] dn_key,
  input  logic [1:0]                         dn_cls,
  output logic signed [rts_pkg::KEY_BITS-1:0] key,
  output logic [1:0]                         cls
);

  logic signed [rts_pkg::KEY_BITS-1:0] key_r, key_nxt;
  logic [1:0]                         cls_r, cls_nxt;
  logic [rts_pkg::CNT_W-1:0]          idx_w, idx_p1;
  logic                               lower, lo_swap, hi_swap;

  assign idx_w  = {1'b0, idx};
  assign idx_p1 = idx_w + 1'b1;
  // lower of a pair when parity of index matches the phase
  assign lower  = (idx[0] == ctl.odd);
  assign lo_swap = lower && (idx_p1 < ctl.cnt) &&
                   (ctl.desc ? (key_r < up_key) : (key_r > up_key));
  assign hi_swap = !lower && (idx != '0) && (idx_w < ctl.cnt) &&
                   (ctl.desc ? (dn_key < key_r) : (dn_key > key_r));

  always_comb begin
    key_nxt = key_r;
    cls_nxt = cls_r;
    unique case (ctl.op)
      rts_pkg::OP_HOLD: begin
      end
      rts_pkg::OP_WRITE: begin
        if (idx == ctl.sel) begin
          key_nxt = ctl.wr_key;
          cls_nxt = ctl.wr_cls;
        end
      end
      rts_pkg::OP_SHIFT: begin
        if (idx >= ctl.sel && idx_p1 < ctl.cnt) begin
          key_nxt = up_key;
          cls_nxt = up_cls;
        end
      end
      rts_pkg::OP_SORT: begin
        if (lo_swap) begin
          key_nxt = up_key;
          cls_nxt = up_cls;
        end else if (hi_swap) begin
          key_nxt = dn_key;
          cls_nxt = dn_cls;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    cls_r <= cls_nxt;
  end

  assign key = key_r;
  assign cls = cls_r;

endmodule

[tb/tb.sv]
module tb;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_mode;
  logic signed [31:0] in_key_id;
  logic signed [31:0] in_new_id;
  logic [1:0]  in_new_class;
  logic [5:0]  in_read_index;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [5:0]  out_found_index;
  logic signed [31:0] out_id;
  logic [1:0]  out_class;
  logic [6:0]  out_entry_total;

  record_table_with_sort u_dut (.*);

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  idx;
    logic [31:0] id;
    logic [1:0]  cls;
    logic [6:0]  total;
  } answer_t;

  // Shadow copy of the table, kept in step with every accepted command.
  logic signed [31:0] shadow_key [rts_pkg::DEPTH];
  logic [1:0]         shadow_cls [rts_pkg::DEPTH];
  int unsigned        shadow_count;
  answer_t            pending_answers[$];

  int  error_count;
  int  item_count;
  int  result_count;
  int  cycle_count;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_cycles;
  int  mode_seen [8];

  // Compute the expected answer of one command and update the shadow table.
  function automatic answer_t table_command(logic [2:0] mode, logic signed [31:0] key,
                                            logic signed [31:0] nkey, logic [1:0] ncls,
                                            logic [5:0] ridx);
    answer_t a;
    int      hit;
    logic signed [31:0] tk;
    logic [1:0] tc;
    a = '0;
    hit = -1;
    for (int i = 0; i < shadow_count; i++)
      if (hit < 0 && shadow_key[i] == key) hit = i;
    if (mode == rts_pkg::MODE_APPEND) begin
      if (ncls == 2'd0) a.status = rts_pkg::ST_BAD_CLASS;
      else if (shadow_count >= rts_pkg::DEPTH) a.status = rts_pkg::ST_FULL;
      else begin
        shadow_key[shadow_count] = nkey;
        shadow_cls[shadow_count] = ncls;
        a.idx = shadow_count;
        a.id  = nkey;
        a.cls = ncls;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      a.status = rts_pkg::ST_EMPTY;
    end else if (mode == rts_pkg::MODE_DELETE || mode == rts_pkg::MODE_REPLACE ||
                 mode == rts_pkg::MODE_FIND) begin
      if (hit < 0) a.status = rts_pkg::ST_NOT_FOUND;
      else if (mode == rts_pkg::MODE_DELETE) begin
        a.idx = hit;
        a.id  = shadow_key[hit];
        a.cls = shadow_cls[hit];
        for (int i = hit; i + 1 < shadow_count; i++) begin
          shadow_key[i] = shadow_key[i+1];
          shadow_cls[i] = shadow_cls[i+1];
        end
        shadow_count--;
      end else if (mode == rts_pkg::MODE_REPLACE && ncls == 2'd0) begin
        a.status = rts_pkg::ST_BAD_CLASS;
      end else begin
        if (mode == rts_pkg::MODE_REPLACE) begin
          shadow_key[hit] = nkey;
          shadow_cls[hit] = ncls;
        end
        a.idx = hit;
        a.id  = shadow_key[hit];
        a.cls = shadow_cls[hit];
      end
    end else if (mode == rts_pkg::MODE_SORT_UP || mode == rts_pkg::MODE_SORT_DN) begin
      for (int i = shadow_count; i > 1; i--)
        for (int j = 0; j + 1 < i; j++)
          if (mode == rts_pkg::MODE_SORT_DN ? shadow_key[j] < shadow_key[j+1]
                                            : shadow_key[j] > shadow_key[j+1]) begin
            tk = shadow_key[j]; tc = shadow_cls[j];
            shadow_key[j] = shadow_key[j+1]; shadow_cls[j] = shadow_cls[j+1];
            shadow_key[j+1] = tk; shadow_cls[j+1] = tc;
          end
    end else if (mode == rts_pkg::MODE_CLEAR) begin
      shadow_count = 0;
    end else begin
      if (ridx >= shadow_count) a.status = rts_pkg::ST_NOT_FOUND;
      else begin
        a.idx = ridx;
        a.id  = shadow_key[ridx];
        a.cls = shadow_cls[ridx];
      end
    end
    a.total = shadow_count;
    return a;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("record_table_with_sort regression: fail");
      $finish;
    end
  end

  // Drive out_ready at the falling edge; a hold request forces a long stall.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each accepted result against the oldest expected answer.
  always @(posedge clk) begin
    answer_t exp_a;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (pending_answers.size() == 0) begin
        $error("result with no command outstanding");
        error_count++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (out_status !== exp_a.status) begin
          $error("status: expected %0d, got %0d", exp_a.status, out_status);
          error_count++;
        end
        if (out_found_index !== exp_a.idx) begin
          $error("found_index: expected %0d, got %0d", exp_a.idx, out_found_index);
          error_count++;
        end
        if (out_id !== exp_a.id) begin
          $error("out_id: expected %0h, got %0h", exp_a.id, out_id);
          error_count++;
        end
        if (out_class !== exp_a.cls) begin
          $error("out_class: expected %0d, got %0d", exp_a.cls, out_class);
          error_count++;
        end
        if (out_entry_total !== exp_a.total) begin
          $error("entry_total: expected %0d, got %0d", exp_a.total, out_entry_total);
          error_count++;
        end
      end
    end
  end

  // Offer one item and hold it until accepted; predict at acceptance.
  // Valid stays high on return so a following item can go back to back.
  task automatic send_command(logic [2:0] mode, logic signed [31:0] key,
                              logic signed [31:0] nkey, logic [1:0] ncls,
                              logic [5:0] ridx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_key_id     <= key;
    in_new_id     <= nkey;
    in_new_class  <= ncls;
    in_read_index <= ridx;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    pending_answers.push_back(table_command(mode, key, nkey, ncls, ridx));
    item_count++;
    mode_seen[mode]++;
    @(negedge clk);
  endtask

  // Key drawn mostly from a small pool so that finds and deletes hit.
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom();
      1: return (shadow_count > 0) ? shadow_key[$urandom_range(shadow_count-1)] : 32'sd7;
      default: return $signed($urandom_range(15)) - 32'sd8;
    endcase
  endfunction

  task automatic random_command();
    int r;
    logic [2:0] mode;
    r = $urandom_range(99);
    // Favor appends; keep sorts and clears rare.
    if (r < 35) mode = rts_pkg::MODE_APPEND;
    else if (r < 50) mode = rts_pkg::MODE_DELETE;
    else if (r < 62) mode = rts_pkg::MODE_REPLACE;
    else if (r < 76) mode = rts_pkg::MODE_FIND;
    else if (r < 80) mode = rts_pkg::MODE_SORT_UP;
    else if (r < 84) mode = rts_pkg::MODE_SORT_DN;
    else if (r < 86) mode = rts_pkg::MODE_CLEAR;
    else mode = rts_pkg::MODE_READ;
    send_command(mode, pick_key(), pick_key(),
                 ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(3)),
                 (shadow_count > 0 && $urandom_range(3) != 0) ?
                   6'($urandom_range(shadow_count-1)) : 6'($urandom()));
  endtask

  // Drop valid, then wait until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Empty-table answers, bad class, extremes of key and index.
  task automatic test_directed();
    for (int m = 1; m < 8; m++) send_command(3'(m), 32'sd0, 32'sd0, 2'd1, 6'd0);
    send_command(rts_pkg::MODE_APPEND, 32'sd0, 32'sh7fffffff, 2'd0, 6'd0);
    send_command(rts_pkg::MODE_APPEND, 32'sd0, 32'sh7fffffff, 2'd3, 6'd0);
    send_command(rts_pkg::MODE_APPEND, 32'sd0, 32'sh80000000, 2'd1, 6'd0);
    send_command(rts_pkg::MODE_APPEND, 32'sd0, 32'sh7fffffff, 2'd2, 6'd0);
    send_command(rts_pkg::MODE_FIND, 32'sh7fffffff, 32'sd0, 2'd0, 6'd0);
    send_command(rts_pkg::MODE_FIND, 32'sd5, 32'sd0, 2'd0, 6'd0);
    send_command(rts_pkg::MODE_REPLACE, 32'sh80000000, 32'sd1, 2'd0, 6'd0);
    send_command(rts_pkg::MODE_REPLACE, 32'sh80000000, 32'sd1, 2'd2, 6'd0);
    send_command(rts_pkg::MODE_READ, 32'sd0, 32'sd0, 2'd0, 6'd63);
    send_command(rts_pkg::MODE_READ, 32'sd0, 32'sd0, 2'd0, 6'd2);
    send_command(rts_pkg::MODE_SORT_DN, 32'sd0, 32'sd0, 2'd0, 6'd0);
    send_command(rts_pkg::MODE_SORT_UP, 32'sd0, 32'sd0, 2'd0, 6'd0);
    send_command(rts_pkg::MODE_DELETE, 32'sh7fffffff, 32'sd0, 2'd0, 6'd0);
    send_command(rts_pkg::MODE_DELETE, 32'sd99, 32'sd0, 2'd0, 6'd0);
    send_command(rts_pkg::MODE_CLEAR, 32'sd0, 32'sd0, 2'd0, 6'd0);
  endtask

  // Fill the table to the top, bounce off full, read the last slot, then sort, find the top key and clear.
  task automatic test_full_table();
    while (shadow_count < rts_pkg::DEPTH)
      send_command(rts_pkg::MODE_APPEND, 32'sd0, $urandom(), 2'($urandom_range(1, 3)), 6'd0);
    send_command(rts_pkg::MODE_APPEND, 32'sd0, 32'sd1, 2'd1, 6'd0);
    send_command(rts_pkg::MODE_READ, 32'sd0, 32'sd0, 2'd0, 6'd63);
    send_command(rts_pkg::MODE_SORT_UP, 32'sd0, 32'sd0, 2'd0, 6'd0);
    send_command(rts_pkg::MODE_FIND, shadow_key[63], 32'sd0, 2'd0, 6'd0);
    send_command(rts_pkg::MODE_CLEAR, 32'sd0, 32'sd0, 2'd0, 6'd0);
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) random_command();
    wait_drained();
  endtask

  // Stall the receiver for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_cycles = 300;
    repeat (10) random_command();
    wait_drained();
  endtask

  initial begin
    in_valid = 1'b0; in_mode = '0; in_key_id = '0; in_new_id = '0;
    in_new_class = '0; in_read_index = '0;
    out_ready = 1'b0; rst_n = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    error_count = 0; item_count = 0; result_count = 0; cycle_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    wait_drained();
    test_full_table();
    wait_drained();
    test_random(50, 0, 0);
    test_random(100, 82, 0);
    test_random(100, 0, 82);
    test_random(100, 34, 34);
    test_backpressure();

    repeat (100) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d results never arrived", pending_answers.size());
      error_count++;
    end
    $display("covered %0d commands (%0d results); per mode: %0d %0d %0d %0d %0d %0d %0d %0d",
             item_count, result_count, mode_seen[0], mode_seen[1], mode_seen[2],
             mode_seen[3], mode_seen[4], mode_seen[5], mode_seen[6], mode_seen[7]);
    $display("idling phases: none, sender, receiver, both, long receiver hold");
    if (error_count == 0) $display("record_table_with_sort regression: pass");
    else $display("record_table_with_sort regression: fail");
    $finish;
  end

endmodule
